>>> sv/kme_pkg.sv
package kme_pkg;

    localparam int KEY_SLOTS   = 16;
    localparam int KEY_W       = 4;
    localparam int MASK_WIDTH  = 4;
    localparam int COL_SEL_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic {
        FUNC_IRQ    = 1'b0,
        FUNC_SAMPLE = 1'b1
    } t_func;

    typedef struct packed {
        logic [MASK_WIDTH-1:0] change;
        logic [MASK_WIDTH-1:0] closed;
        logic [KEY_W-1:0]      base;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_qwr;

    typedef struct packed {
        logic empty;
        t_job job;
    } t_qrd;

endpackage

>>> sv/kme_front.sv
module kme_front #(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic                          push,
    input  logic                          i_func,
    input  logic [1:0]                    i_row_index,
    input  logic [kme_pkg::MASK_WIDTH-1:0] i_column_bits,
    input  logic                          i_read_ok,
    input  logic                          i_q_full,
    output kme_pkg::t_qwr                 o_qwr
);
    import kme_pkg::*;

    localparam int KSUM_W = $clog2(4 * COLUMN_COUNT + KEY_SLOTS);

    logic                  r_events_enabled;
    logic                  r_scan_pending;
    logic                  n_scan_pending;
    logic [KEY_SLOTS-1:0]  r_key_down;
    logic [KEY_SLOTS-1:0]  n_key_down;
    logic                  w_accept;
    logic                  w_row_ok;
    logic                  w_apply;
    logic [KSUM_W-1:0]     w_key [MASK_WIDTH];
    logic [KEY_W-1:0]      w_key4 [MASK_WIDTH];
    logic [MASK_WIDTH-1:0] w_change;

    assign w_accept = push && !i_q_full;
    assign w_row_ok = int'(i_row_index) < ROW_COUNT;
    assign w_apply  = w_accept && (t_func'(i_func) == FUNC_SAMPLE) && r_scan_pending
                      && i_read_ok && w_row_ok;

    // per-column key number and change detect
    always_comb begin
        for (int j = 0; j < MASK_WIDTH; j++) begin
            w_key[j]  = KSUM_W'(j) + KSUM_W'(i_row_index) * KSUM_W'(COLUMN_COUNT);
            w_key4[j] = w_key[j][KEY_W-1:0];
            w_change[j] = (j < COLUMN_COUNT) && (w_key[j] < KSUM_W'(KEY_SLOTS))
                          && (i_column_bits[j] != r_key_down[w_key4[j]]);
        end
    end

    always_comb begin
        n_key_down     = r_key_down;
        n_scan_pending = r_scan_pending;
        if (w_accept) begin
            if (t_func'(i_func) == FUNC_IRQ) begin
                if (r_events_enabled) begin
                    n_scan_pending = 1'b1;
                end
            end else if (r_scan_pending) begin
                if (!i_read_ok) begin
                    n_scan_pending = 1'b0;
                end else if (w_row_ok) begin
                    for (int j = 0; j < MASK_WIDTH; j++) begin
                        if (w_change[j]) begin
                            n_key_down[w_key4[j]] = i_column_bits[j];
                        end
                    end
                    if (int'(i_row_index) == ROW_COUNT - 1) begin
                        n_scan_pending = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_events_enabled <= 1'b0;
            r_scan_pending   <= 1'b0;
            r_key_down       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_events_enabled <= i_cfg_wr_data;
            end
            r_scan_pending <= n_scan_pending;
            r_key_down     <= n_key_down;
        end
    end

    assign o_qwr.push       = w_apply && (w_change != '0);
    assign o_qwr.job.change = w_change;
    assign o_qwr.job.closed = i_column_bits;
    assign o_qwr.job.base   = w_key4[0];

endmodule

>>> sv/kme_queue.sv
module kme_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kme_pkg::t_qwr i_qwr,
    input  logic          i_pop,
    output logic          o_full,
    output kme_pkg::t_qrd o_qrd
);
    import kme_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full      = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_qrd.empty = r_count == '0;
    assign o_qrd.job   = r_mem[r_rd_ptr];
    assign w_push      = i_qwr.push && !o_full;
    assign w_pop       = i_pop && !o_qrd.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_qwr.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/kme_back.sv
module kme_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  kme_pkg::t_qrd          i_qrd,
    output logic                   o_q_pop,
    output logic                   empty,
    input  logic                   pop,
    output logic [kme_pkg::KEY_W-1:0] o_key_index,
    output logic                   o_is_press,
    output logic                   o_last_event
);
    import kme_pkg::*;

    logic [MASK_WIDTH-1:0] r_done;
    logic                  r_out_valid;
    logic [MASK_WIDTH-1:0] w_remain;
    logic [MASK_WIDTH-1:0] w_sel;
    logic [COL_SEL_W-1:0]  w_col;
    logic                  w_found;
    logic                  w_advance;
    logic                  w_last;

    assign w_remain = i_qrd.job.change & ~r_done;

    // lowest remaining column first
    always_comb begin
        w_sel   = '0;
        w_col   = '0;
        w_found = 1'b0;
        for (int j = 0; j < MASK_WIDTH; j++) begin
            if (w_remain[j] && !w_found) begin
                w_found  = 1'b1;
                w_sel[j] = 1'b1;
                w_col    = COL_SEL_W'(j);
            end
        end
    end

    assign w_advance = !i_qrd.empty && (!r_out_valid || pop);
    assign w_last    = (w_remain & ~w_sel) == '0;
    assign o_q_pop   = w_advance && w_last;
    assign empty     = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_key_index  <= i_qrd.job.base + KEY_W'(w_col);
            o_is_press   <= i_qrd.job.closed[w_col];
            o_last_event <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_done      <= w_last ? '0 : (r_done | w_sel);
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> sv/keypad_matrix_edge_events.sv
// keypad matrix scanner with interrupt gating and per-key edge events
// requests come in through push/full: func 0 is an interrupt edge that arms
// a scan when events are enabled, func 1 is a row sample with its column mask
// and read status. a request is taken on any cycle full is low, so one
// request per cycle is sustained while the event queue has room.
// each changed key of an accepted row sample becomes one event on the
// empty/pop side, lowest column first, with last_event on the final one.
// the event unit emits one event per cycle while the output is not stalled,
// so a sample with n changed keys (at most four) yields n events in turn; its
// job passes through the queue and then the output register before it shows.
// a four-entry job queue sits between sample decode and event output; it
// absorbs bursts and raises full only when four change jobs are waiting.
// when pop stays low the current event holds on the output ports and
// further jobs wait in the queue.
// synchronous reset clears the enable register, the pending flag, all key
// states (released), the job queue and the output stage.
// i_cfg_wr_en with i_cfg_wr_data writes the events-enabled bit; write it
// only while no events are outstanding.
module keypad_matrix_edge_events #(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic       i_func,
    input  logic [1:0] i_row_index,
    input  logic [3:0] i_column_bits,
    input  logic       i_read_ok,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_key_index,
    output logic       o_is_press,
    output logic       o_last_event
);
    import kme_pkg::*;

    t_qwr w_qwr;
    t_qrd w_qrd;
    logic w_q_pop;

    kme_front #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .i_func        (i_func),
        .i_row_index   (i_row_index),
        .i_column_bits (i_column_bits),
        .i_read_ok     (i_read_ok),
        .i_q_full      (full),
        .o_qwr         (w_qwr)
    );

    kme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (w_qwr),
        .i_pop   (w_q_pop),
        .o_full  (full),
        .o_qrd   (w_qrd)
    );

    kme_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qrd        (w_qrd),
        .o_q_pop      (w_q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_key_index  (o_key_index),
        .o_is_press   (o_is_press),
        .o_last_event (o_last_event)
    );

endmodule

>>> sv/kme_checker.sv
module kme_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [3:0] o_key_index,
    input logic       o_is_press,
    input logic       o_last_event
);

    // reset leaves no events and room for requests
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("events visible after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");

    // a stalled event holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_key_index) && $stable(o_is_press)
                              && $stable(o_last_event)))
        else $error("stalled event changed");

    // events of one row sample follow at once in rising key order
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_event) |=> (!empty && (o_key_index > $past(o_key_index))))
        else $error("event run broken or out of order");

endmodule

bind keypad_matrix_edge_events kme_checker u_kme_checker (.*);

>>> bench/tb_keypad_matrix_edge_events.sv
`timescale 1ns / 100ps

module tb_keypad_matrix_edge_events;
    import kme_pkg::*;

    localparam int ROWS        = 4;
    localparam int COLS        = 4;
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_func      func;
        logic [1:0] row;
        logic [3:0] cols;
        logic       read_ok;
    } t_scan_req;

    typedef struct packed {
        logic [3:0] key;
        logic       press;
        logic       last;
    } t_key_event;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       push          = 1'b0;
    logic       i_func        = 1'b0;
    logic [1:0] i_row_index   = '0;
    logic [3:0] i_column_bits = '0;
    logic       i_read_ok     = 1'b0;
    logic       pop           = 1'b0;
    logic       full;
    logic       empty;
    logic [3:0] o_key_index;
    logic       o_is_press;
    logic       o_last_event;

    t_scan_req  scan_req_q[$];
    t_key_event key_event_q[$];
    t_scan_req  req_in_flight;

    logic       events_on  = 1'b0;
    logic       scan_armed = 1'b0;
    logic       key_state [16];

    int send_idle_pct = 22;
    int recv_idle_pct = 75;
    int cycle_count   = 0;
    int error_count   = 0;
    int n_requests    = 0;
    int n_events      = 0;
    int n_cfg_writes  = 0;

    keypad_matrix_edge_events #(
        .ROW_COUNT    (ROWS),
        .COLUMN_COUNT (COLS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_row_index   (i_row_index),
        .i_column_bits (i_column_bits),
        .i_read_ok     (i_read_ok),
        .empty         (empty),
        .pop           (pop),
        .o_key_index   (o_key_index),
        .o_is_press    (o_is_press),
        .o_last_event  (o_last_event)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void predict_key_events(t_scan_req r);
        int         n;
        logic [3:0] key;
        n = 0;
        if (r.func == FUNC_IRQ) begin
            if (events_on) scan_armed = 1'b1;
            return;
        end
        if (!scan_armed) return;
        if (!r.read_ok) begin
            scan_armed = 1'b0;
            return;
        end
        if (r.row >= ROWS) return;
        for (int j = 0; j < COLS; j++) begin
            key = 4'(j + r.row * COLS);
            if (r.cols[j] != key_state[key]) begin
                key_state[key] = r.cols[j];
                key_event_q.push_back('{key: key, press: r.cols[j], last: 1'b0});
                n++;
            end
        end
        if (n > 0) key_event_q[key_event_q.size() - 1].last = 1'b1;
        if (r.row == ROWS - 1) scan_armed = 1'b0;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_requests
        t_scan_req r;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_key_events(req_in_flight);
                n_requests++;
            end
            if (!push || !full) begin
                if (scan_req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    r = scan_req_q.pop_front();
                    req_in_flight = r;
                    push          <= 1'b1;
                    i_func        <= r.func;
                    i_row_index   <= r.row;
                    i_column_bits <= r.cols;
                    i_read_ok     <= r.read_ok;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_events
        t_key_event ev;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_events++;
                if (key_event_q.size() == 0) begin
                    $error("unexpected key event: key %0d press %0b", o_key_index, o_is_press);
                    error_count++;
                end else begin
                    ev = key_event_q.pop_front();
                    if (o_key_index !== ev.key) begin
                        $error("key_index: expected %0d, actual %0d", ev.key, o_key_index);
                        error_count++;
                    end
                    if (o_is_press !== ev.press) begin
                        $error("is_press: expected %0b, actual %0b", ev.press, o_is_press);
                        error_count++;
                    end
                    if (o_last_event !== ev.last) begin
                        $error("last_event: expected %0b, actual %0b", ev.last, o_last_event);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic add_req(t_func f, logic [1:0] row, logic [3:0] cols, logic ok);
        scan_req_q.push_back('{func: f, row: row, cols: cols, read_ok: ok});
    endtask

    task automatic add_random_requests(int count);
        int added;
        int last_row;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 9) < 8) begin
                add_req(FUNC_IRQ, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)));
                added++;
                last_row = ($urandom_range(0, 9) < 8) ? ROWS - 1 : $urandom_range(0, ROWS - 1);
                for (int row = 0; row <= last_row; row++) begin
                    add_req(FUNC_SAMPLE, 2'(row), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 19) != 0));
                    added++;
                end
            end else begin
                add_req(t_func'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                        4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (scan_req_q.size() != 0 || push || key_event_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_enable(logic value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        events_on = value;
        n_cfg_writes++;
    endtask

    initial begin
        for (int k = 0; k < 16; k++) key_state[k] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: interrupt and sample both ignored
        add_req(FUNC_IRQ, 2'd3, 4'hF, 1'b1);
        add_req(FUNC_SAMPLE, 2'd0, 4'hF, 1'b1);
        wait_idle();
        write_enable(1'b1);

        // full scan, repeated interrupt while pending
        add_req(FUNC_IRQ, 2'd0, 4'h0, 1'b0);
        add_req(FUNC_IRQ, 2'd0, 4'h0, 1'b0);
        add_req(FUNC_SAMPLE, 2'd0, 4'hF, 1'b1);
        add_req(FUNC_SAMPLE, 2'd1, 4'h0, 1'b1);
        add_req(FUNC_SAMPLE, 2'd2, 4'h5, 1'b1);
        add_req(FUNC_SAMPLE, 2'd3, 4'hF, 1'b1);
        add_req(FUNC_SAMPLE, 2'd0, 4'h0, 1'b1);
        // failed read aborts the scan
        add_req(FUNC_IRQ, 2'd0, 4'h0, 1'b1);
        add_req(FUNC_SAMPLE, 2'd0, 4'h0, 1'b1);
        add_req(FUNC_SAMPLE, 2'd1, 4'hA, 1'b0);
        add_req(FUNC_SAMPLE, 2'd2, 4'h0, 1'b1);
        add_req(FUNC_IRQ, 2'd1, 4'hA, 1'b1);
        add_req(FUNC_SAMPLE, 2'd0, 4'h1, 1'b1);
        add_req(FUNC_SAMPLE, 2'd1, 4'hF, 1'b1);
        add_req(FUNC_SAMPLE, 2'd2, 4'hA, 1'b1);
        add_req(FUNC_SAMPLE, 2'd3, 4'h0, 1'b1);
        add_req(FUNC_IRQ, 2'd2, 4'h5, 1'b0);
        add_req(FUNC_SAMPLE, 2'd0, 4'h8, 1'b1);
        wait_idle();
        // disabled with a scan still pending
        write_enable(1'b0);
        add_req(FUNC_SAMPLE, 2'd1, 4'h0, 1'b1);
        add_req(FUNC_SAMPLE, 2'd2, 4'h0, 1'b1);
        add_req(FUNC_SAMPLE, 2'd3, 4'hF, 1'b1);
        add_req(FUNC_IRQ, 2'd3, 4'hF, 1'b1);
        add_req(FUNC_SAMPLE, 2'd0, 4'hF, 1'b1);
        wait_idle();

        write_enable(1'b1);
        add_random_requests(100);
        wait_idle();
        write_enable(1'b0);
        add_random_requests(20);
        wait_idle();

        send_idle_pct = 75;
        recv_idle_pct = 22;
        write_enable(1'b1);
        add_random_requests(100);
        wait_idle();
        write_enable(1'b0);
        add_random_requests(15);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_enable(1'b1);
        add_random_requests(100);
        wait_idle();

        $display("%0d requests sent, %0d key events checked, %0d enable writes",
                 n_requests, n_events, n_cfg_writes);
        $display("covered full and aborted scans, disabled interrupts and mixed stalls");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
